FILE: hdl/gaussian_blur_7x7_top_defines.svh
// Assertion macros used by the checker file gb7_checker.sv.
`ifndef GAUSSIAN_BLUR_7X7_TOP_DEFINES_SVH
`define GAUSSIAN_BLUR_7X7_TOP_DEFINES_SVH

// Check that cons holds in the cycle after ante, outside reset.
`define GB7_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

// Check that cons holds in the cycle after each cycle with reset low.
`define GB7_ASSERT_AFTER_RST(lbl, cons, msg) \
    lbl: assert property (@(posedge i_clk) (!i_rst_n) |=> (cons)) else $error(msg);

`endif

FILE: hdl/gb7_pkg.sv
`default_nettype none

package gb7_pkg;

    localparam int MAX_WIDTH         = 1024;
    localparam int KERNEL_SIZE       = 7;
    localparam int TAP_FRACTION_BITS = 8;

    localparam int LINE_COUNT  = KERNEL_SIZE - 1;
    localparam int HALF_KERNEL = KERNEL_SIZE / 2;
    localparam int MAX_HEIGHT  = 1024;

    localparam int PIX_W     = 8;
    localparam int PIX_MAX   = 255;
    localparam int CFG_W     = 11;
    localparam int CFG_IDX_W = 1;
    localparam int OUT_W     = 10;
    localparam int ROW_CNT_W = $clog2(MAX_HEIGHT);
    localparam int COL_W     = $clog2(MAX_WIDTH);
    localparam int EFF_W     = (COL_W + 1 > CFG_W) ? COL_W + 1 : CFG_W;
    localparam int SLOT_W    = $clog2(LINE_COUNT);

    localparam int CFG_WIDTH_RST  = 640;
    localparam int CFG_HEIGHT_RST = 480;

    localparam int Q_DEPTH = 4;
    localparam int Q_PTR_W = $clog2(Q_DEPTH);
    localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);
    localparam int LVL_W   = Q_CNT_W + 1;

    localparam int TAP_W = TAP_FRACTION_BITS;
    localparam int SHIFT = 2 * TAP_FRACTION_BITS;

    localparam int Q8_TAPS [KERNEL_SIZE] = '{3, 20, 61, 88, 61, 20, 3};

    typedef logic [TAP_W-1:0] t_tap_arr [KERNEL_SIZE];

    function automatic t_tap_arr tap_table();
        t_tap_arr t;
        longint   v;
        for (int k = 0; k < KERNEL_SIZE; k++) begin
            v    = ((longint'(Q8_TAPS[k]) <<< TAP_FRACTION_BITS) + 128) >>> 8;
            t[k] = TAP_W'(v);
        end
        return t;
    endfunction

    function automatic longint tap_sum();
        longint s;
        s = 0;
        for (int k = 0; k < KERNEL_SIZE; k++) begin
            s = s + (((longint'(Q8_TAPS[k]) <<< TAP_FRACTION_BITS) + 128) >>> 8);
        end
        return s;
    endfunction

    localparam t_tap_arr TAPS    = tap_table();
    localparam longint   TAP_SUM = tap_sum();
    localparam int ROW_SUM_W = $clog2(longint'(PIX_MAX) * TAP_SUM + 1);
    localparam int TOT_W     = $clog2(longint'(PIX_MAX) * TAP_SUM * TAP_SUM + 1);

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_FRAME_WIDTH  = 1'b0,
        CFG_FRAME_HEIGHT = 1'b1
    } t_cfg_reg;

    typedef struct packed {
        logic [KERNEL_SIZE-1:0][PIX_W-1:0] column;
        logic                              emit;
        logic [OUT_W-1:0]                  out_row;
        logic [OUT_W-1:0]                  out_col;
        logic                              frame_last;
    } t_col_beat;

    typedef struct packed {
        logic [Q_CNT_W-1:0] level;
        logic               not_empty;
    } t_queue_status;

endpackage

`default_nettype wire

FILE: hdl/gb7_front.sv
`default_nettype none

module gb7_front import gb7_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  logic [PIX_W-1:0]     i_pixel,
    input  logic                 i_frame_start,
    input  logic                 i_cfg_wr_en,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [CFG_W-1:0]     i_cfg_data,
    input  t_queue_status        i_q_status,
    output logic                 o_push,
    output t_col_beat            o_beat
);

    logic [CFG_W-1:0]     r_frame_width;
    logic [CFG_W-1:0]     r_frame_height;
    logic [COL_W-1:0]     r_col;
    logic [ROW_CNT_W-1:0] r_row;
    logic [SLOT_W-1:0]    r_slot;
    logic [COL_W-1:0]     n_col;
    logic [ROW_CNT_W-1:0] n_row;
    logic [SLOT_W-1:0]    n_slot;

    logic [EFF_W-1:0]     eff_w;
    logic [CFG_W-1:0]     eff_h;
    logic                 accept;
    logic                 restart_row;
    logic                 restart_col;
    logic [COL_W-1:0]     cur_col;
    logic [ROW_CNT_W-1:0] cur_row;
    logic [SLOT_W-1:0]    cur_slot;
    logic                 col_end;
    logic                 row_end;

    logic [PIX_W-1:0]     r_rd_data [LINE_COUNT];

    logic                 r_s1_v;
    logic [PIX_W-1:0]     r_s1_px;
    logic [SLOT_W-1:0]    r_s1_slot;
    logic                 r_s1_emit;
    logic [OUT_W-1:0]     r_s1_row;
    logic [OUT_W-1:0]     r_s1_col;
    logic                 r_s1_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_width  <= CFG_W'(CFG_WIDTH_RST);
            r_frame_height <= CFG_W'(CFG_HEIGHT_RST);
        end else if (i_cfg_wr_en) begin
            unique case (t_cfg_reg'(i_cfg_index))
                CFG_FRAME_WIDTH:  r_frame_width  <= i_cfg_data;
                CFG_FRAME_HEIGHT: r_frame_height <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_comb begin
        if (r_frame_width == '0) begin
            eff_w = EFF_W'(1);
        end else if (EFF_W'(r_frame_width) > EFF_W'(MAX_WIDTH)) begin
            eff_w = EFF_W'(MAX_WIDTH);
        end else begin
            eff_w = EFF_W'(r_frame_width);
        end
        if (r_frame_height == '0) begin
            eff_h = CFG_W'(1);
        end else if (r_frame_height > CFG_W'(MAX_HEIGHT)) begin
            eff_h = CFG_W'(MAX_HEIGHT);
        end else begin
            eff_h = r_frame_height;
        end
    end

    assign o_in_stall = (LVL_W'(i_q_status.level) + LVL_W'(r_s1_v)) >= LVL_W'(Q_DEPTH);
    assign accept     = i_in_valid && !o_in_stall;

    always_comb begin
        restart_col = i_frame_start || (EFF_W'(r_col) >= eff_w);
        restart_row = i_frame_start || (CFG_W'(r_row) >= eff_h);
        cur_col     = restart_col ? '0 : r_col;
        cur_row     = restart_row ? '0 : r_row;
        cur_slot    = restart_row ? '0 : r_slot;
        col_end     = (EFF_W'(cur_col) + EFF_W'(1)) >= eff_w;
        row_end     = (CFG_W'(cur_row) + CFG_W'(1)) >= eff_h;
        if (col_end) begin
            n_col = '0;
            if (row_end) begin
                n_row  = '0;
                n_slot = '0;
            end else begin
                n_row  = cur_row + ROW_CNT_W'(1);
                n_slot = (cur_slot == SLOT_W'(LINE_COUNT - 1)) ? '0 : cur_slot + SLOT_W'(1);
            end
        end else begin
            n_col  = cur_col + COL_W'(1);
            n_row  = cur_row;
            n_slot = cur_slot;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col  <= '0;
            r_row  <= '0;
            r_slot <= '0;
            r_s1_v <= 1'b0;
        end else begin
            r_s1_v <= accept;
            if (accept) begin
                r_col  <= n_col;
                r_row  <= n_row;
                r_slot <= n_slot;
            end
        end
    end

    for (genvar l = 0; l < LINE_COUNT; l++) begin : g_line
        logic [PIX_W-1:0] r_line_mem [MAX_WIDTH];

        always_ff @(posedge i_clk) begin
            if (accept) begin
                r_rd_data[l] <= r_line_mem[cur_col];
                if (cur_slot == SLOT_W'(l)) begin
                    r_line_mem[cur_col] <= i_pixel;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_px   <= i_pixel;
            r_s1_slot <= cur_slot;
            r_s1_emit <= (cur_row >= ROW_CNT_W'(LINE_COUNT)) && (cur_col >= COL_W'(LINE_COUNT));
            r_s1_row  <= OUT_W'(cur_row - ROW_CNT_W'(HALF_KERNEL));
            r_s1_col  <= OUT_W'(cur_col - COL_W'(HALF_KERNEL));
            r_s1_last <= col_end && row_end
                         && ((CFG_W'(cur_row) + CFG_W'(1)) == eff_h)
                         && ((EFF_W'(cur_col) + EFF_W'(1)) == eff_w);
        end
    end

    // rotate line outputs so window row 0 is the oldest line
    always_comb begin
        o_beat.column = '0;
        for (int s = 0; s < LINE_COUNT; s++) begin
            if (r_s1_slot == SLOT_W'(s)) begin
                for (int rr = 0; rr < LINE_COUNT; rr++) begin
                    o_beat.column[rr] = r_rd_data[(s + rr) % LINE_COUNT];
                end
            end
        end
        o_beat.column[KERNEL_SIZE-1] = r_s1_px;
        o_beat.emit                  = r_s1_emit;
        o_beat.out_row               = r_s1_row;
        o_beat.out_col               = r_s1_col;
        o_beat.frame_last            = r_s1_last;
    end

    assign o_push = r_s1_v;

endmodule

`default_nettype wire

FILE: hdl/gb7_queue.sv
`default_nettype none

module gb7_queue import gb7_pkg::*; (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  t_col_beat     i_beat,
    input  logic          i_pop,
    output t_col_beat     o_beat,
    output t_queue_status o_status
);

    t_col_beat          r_q_mem [Q_DEPTH];
    logic [Q_PTR_W-1:0] r_wr_ptr;
    logic [Q_PTR_W-1:0] r_rd_ptr;
    logic [Q_CNT_W-1:0] r_count;
    logic [Q_PTR_W-1:0] n_wr_ptr;
    logic [Q_PTR_W-1:0] n_rd_ptr;

    assign n_wr_ptr = (r_wr_ptr == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : r_wr_ptr + Q_PTR_W'(1);
    assign n_rd_ptr = (r_rd_ptr == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : r_rd_ptr + Q_PTR_W'(1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= n_wr_ptr;
            end
            if (i_pop) begin
                r_rd_ptr <= n_rd_ptr;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + Q_CNT_W'(1);
            end else if (!i_push && i_pop) begin
                r_count <= r_count - Q_CNT_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_q_mem[r_wr_ptr] <= i_beat;
        end
    end

    assign o_beat             = r_q_mem[r_rd_ptr];
    assign o_status.level     = r_count;
    assign o_status.not_empty = (r_count != '0);

endmodule

`default_nettype wire

FILE: hdl/gb7_back.sv
`default_nettype none

module gb7_back import gb7_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_queue_status    i_q_status,
    input  t_col_beat        i_beat,
    output logic             o_pop,
    output logic             o_out_valid,
    input  logic             i_out_stall,
    output logic [PIX_W-1:0] o_blurred,
    output logic [OUT_W-1:0] o_out_row,
    output logic [OUT_W-1:0] o_out_col,
    output logic             o_frame_last
);

    logic [PIX_W-1:0]     r_win [KERNEL_SIZE][KERNEL_SIZE];
    logic [PIX_W-1:0]     n_win [KERNEL_SIZE][KERNEL_SIZE];
    logic [ROW_SUM_W-1:0] n_rowsum [KERNEL_SIZE];
    logic [TOT_W-1:0]     n_total;
    logic [TOT_W-1:0]     b_shift;
    logic [PIX_W-1:0]     n_blurred;
    logic                 advance;

    logic                 r_a_v;
    logic [ROW_SUM_W-1:0] r_a_rowsum [KERNEL_SIZE];
    logic [OUT_W-1:0]     r_a_row;
    logic [OUT_W-1:0]     r_a_col;
    logic                 r_a_last;

    logic                 r_b_v;
    logic [TOT_W-1:0]     r_b_total;
    logic [OUT_W-1:0]     r_b_row;
    logic [OUT_W-1:0]     r_b_col;
    logic                 r_b_last;

    logic                 r_out_v;
    logic [PIX_W-1:0]     r_out_blurred;
    logic [OUT_W-1:0]     r_out_row;
    logic [OUT_W-1:0]     r_out_col;
    logic                 r_out_last;

    assign advance = !r_out_v || !i_out_stall;
    assign o_pop   = advance && i_q_status.not_empty;

    // shift window left, new column enters on the right
    always_comb begin
        for (int r = 0; r < KERNEL_SIZE; r++) begin
            for (int c = 0; c < KERNEL_SIZE - 1; c++) begin
                n_win[r][c] = r_win[r][c+1];
            end
            n_win[r][KERNEL_SIZE-1] = i_beat.column[r];
        end
    end

    always_comb begin
        for (int r = 0; r < KERNEL_SIZE; r++) begin
            n_rowsum[r] = '0;
            for (int c = 0; c < KERNEL_SIZE; c++) begin
                n_rowsum[r] = n_rowsum[r] + ROW_SUM_W'(TAPS[c]) * ROW_SUM_W'(n_win[r][c]);
            end
        end
    end

    always_comb begin
        n_total = '0;
        for (int r = 0; r < KERNEL_SIZE; r++) begin
            n_total = n_total + TOT_W'(TAPS[r]) * TOT_W'(r_a_rowsum[r]);
        end
    end

    always_comb begin
        b_shift   = r_b_total >> SHIFT;
        n_blurred = (b_shift > TOT_W'(PIX_MAX)) ? PIX_W'(PIX_MAX) : b_shift[PIX_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_v   <= 1'b0;
            r_b_v   <= 1'b0;
            r_out_v <= 1'b0;
            for (int r = 0; r < KERNEL_SIZE; r++) begin
                for (int c = 0; c < KERNEL_SIZE; c++) begin
                    r_win[r][c] <= '0;
                end
            end
        end else if (advance) begin
            r_a_v   <= o_pop && i_beat.emit;
            r_b_v   <= r_a_v;
            r_out_v <= r_b_v;
            if (o_pop) begin
                r_win <= n_win;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_a_rowsum    <= n_rowsum;
            r_a_row       <= i_beat.out_row;
            r_a_col       <= i_beat.out_col;
            r_a_last      <= i_beat.frame_last;
            r_b_total     <= n_total;
            r_b_row       <= r_a_row;
            r_b_col       <= r_a_col;
            r_b_last      <= r_a_last;
            r_out_blurred <= n_blurred;
            r_out_row     <= r_b_row;
            r_out_col     <= r_b_col;
            r_out_last    <= r_b_last;
        end
    end

    assign o_out_valid  = r_out_v;
    assign o_blurred    = r_out_blurred;
    assign o_out_row    = r_out_row;
    assign o_out_col    = r_out_col;
    assign o_frame_last = r_out_last;

endmodule

`default_nettype wire

FILE: hdl/gaussian_blur_7x7_top.sv
// Channel   Handshake                  Payload
// input     i_in_valid / o_in_stall    i_pixel, i_frame_start
// output    o_out_valid / i_out_stall  o_blurred, o_out_row, o_out_col, o_frame_last
// config    i_cfg_wr_en                i_cfg_index, i_cfg_data
//
// One pixel per cycle unless stalled; each line buffer has a read and a write port.
// Each taken pixel goes through line read, the queue, then back stages a, b and out.
// Reset is synchronous: counters, window and queue clear, size returns to 640 x 480.
// Line buffers are not cleared; no clearing pass is run.
// Output stall freezes the back pipeline; a four-entry queue absorbs the front,
// and o_in_stall rises once queued beats plus the line read stage beat reach four.
`default_nettype none

module gaussian_blur_7x7_top import gb7_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  logic [PIX_W-1:0]     i_pixel,
    input  logic                 i_frame_start,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output logic [PIX_W-1:0]     o_blurred,
    output logic [OUT_W-1:0]     o_out_row,
    output logic [OUT_W-1:0]     o_out_col,
    output logic                 o_frame_last,
    input  logic                 i_cfg_wr_en,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [CFG_W-1:0]     i_cfg_data
);

    logic          push;
    logic          pop;
    t_col_beat     front_beat;
    t_col_beat     queue_beat;
    t_queue_status q_status;

    gb7_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_pixel       (i_pixel),
        .i_frame_start (i_frame_start),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .i_q_status    (q_status),
        .o_push        (push),
        .o_beat        (front_beat)
    );

    gb7_queue u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .i_beat   (front_beat),
        .i_pop    (pop),
        .o_beat   (queue_beat),
        .o_status (q_status)
    );

    gb7_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_q_status   (q_status),
        .i_beat       (queue_beat),
        .o_pop        (pop),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_blurred    (o_blurred),
        .o_out_row    (o_out_row),
        .o_out_col    (o_out_col),
        .o_frame_last (o_frame_last)
    );

endmodule

`default_nettype wire

FILE: hdl/gb7_checker.sv
`default_nettype none
`include "gaussian_blur_7x7_top_defines.svh"

module gb7_checker import gb7_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_stall,
    input  logic             i_out_valid,
    input  logic             i_out_stall,
    input  logic [PIX_W-1:0] i_blurred,
    input  logic [OUT_W-1:0] i_out_row,
    input  logic [OUT_W-1:0] i_out_col,
    input  logic             i_frame_last
);

    logic [PIX_W+2*OUT_W:0] out_payload;

    assign out_payload = {i_blurred, i_out_row, i_out_col, i_frame_last};

    `GB7_ASSERT_NEXT(a_out_hold, i_out_valid && i_out_stall, i_out_valid, "result dropped")
    `GB7_ASSERT_NEXT(a_out_stable, i_out_valid && i_out_stall, $stable(out_payload), "result changed")
    `GB7_ASSERT_AFTER_RST(a_rst_no_result, !i_out_valid, "result shown after reset")
    `GB7_ASSERT_AFTER_RST(a_rst_ready, !i_in_stall, "input stalled after reset")

endmodule

bind gaussian_blur_7x7_top gb7_checker u_gb7_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_in_stall   (o_in_stall),
    .i_out_valid  (o_out_valid),
    .i_out_stall  (i_out_stall),
    .i_blurred    (o_blurred),
    .i_out_row    (o_out_row),
    .i_out_col    (o_out_col),
    .i_frame_last (o_frame_last)
);

`default_nettype wire
